// ----- rtl/cgrs_pkg.sv -----
// ----------------------------------------------------------------------------
// cgrs_pkg
// Shared types, codes and constants of the capped grid regrowth store.
// ----------------------------------------------------------------------------
package cgrs_pkg;

    // default grid geometry
    localparam int GRID_COLUMNS_DEF = 64;
    localparam int GRID_ROWS_DEF    = 64;

    // field widths fixed by the interface
    localparam int DATA_W    = 32;
    localparam int COORD_W   = 6;
    localparam int SIZE_W    = 7;
    localparam int CFG_IDX_W = 3;

    // Q16.16 constants
    localparam logic signed [DATA_W-1:0] Q_ONE   = 32'sh0001_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

    // operation codes
    typedef enum logic [2:0] {
        OP_WRITE_VALUE = 3'd0,
        OP_WRITE_CAP   = 3'd1,
        OP_READ_CAP    = 3'd2,
        OP_TICK        = 3'd3,
        OP_SCAN        = 3'd4,
        OP_INIT_FILL   = 3'd5
    } op_t;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_GLOBAL = 3'd1,
        ST_X      = 3'd2,
        ST_Y      = 3'd3,
        ST_CAP    = 3'd4
    } status_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 3'd0,
        CFG_HEIGHT = 3'd1,
        CFG_GMAX   = 3'd2,
        CFG_GMIN   = 3'd3,
        CFG_AUTO   = 3'd4
    } cfg_idx_t;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_DRAIN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [2:0]                operation;
        logic [COORD_W-1:0]        x_index;
        logic [COORD_W-1:0]        y_index;
        logic signed [DATA_W-1:0]  write_value;
    } in_item_t;

    typedef struct packed {
        status_t                   status;
        logic signed [DATA_W-1:0]  read_cap;
        logic signed [DATA_W-1:0]  tracked_min;
        logic signed [DATA_W-1:0]  tracked_max;
    } out_item_t;

    // configuration as seen by the datapath (sizes already clamped)
    typedef struct packed {
        logic [SIZE_W-1:0]         eff_width;
        logic [SIZE_W-1:0]         eff_height;
        logic signed [DATA_W-1:0]  global_max;
        logic signed [DATA_W-1:0]  global_min;
        logic                      auto_on;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic mem_read;
        logic sweep_step;
        logic finish;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic sweep_go;
        logic sweep_last;
    } dp_sts_t;

endpackage

// ----- rtl/capped_grid_regrowth_store_unit.sv -----
// ----------------------------------------------------------------------------
// capped_grid_regrowth_store_unit
// Grid of Q16.16 cell values with per-cell caps: checked writes, cap read,
// regrowth tick, min/max scan and init fill.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------
//  in       | in_valid / in_ready  | in_data  (operation, x, y, value)
//  out      | out_valid / out_ready| out_data (status, cap, min, max)
//  config   | cfg_we               | cfg_addr, cfg_wdata
//
//  Single-cell operations: the accept cycle reads the memories, then the finish
//  state checks, writes and loads the result register once the output is free.
//  Tick, scan and init fill sweep one cell per cycle through the single memory
//  read port, then a drain state processes the last read.
//  One item is in work at a time; a new item is taken while the previous
//  result waits. A result that is not taken stalls the next one in its
//  final cycle. Reset clears control state only; cells are undefined.
// ----------------------------------------------------------------------------
module capped_grid_regrowth_store_unit #(
    parameter int GRID_COLUMNS = cgrs_pkg::GRID_COLUMNS_DEF,
    parameter int GRID_ROWS    = cgrs_pkg::GRID_ROWS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  cgrs_pkg::in_item_t              in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output cgrs_pkg::out_item_t             out_data,
    input  logic                            cfg_we,
    input  logic [cgrs_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [cgrs_pkg::DATA_W-1:0]     cfg_wdata
);
    import cgrs_pkg::*;

    cfg_t    cfg;
    dp_cmd_t cmd;
    dp_sts_t sts;

    cgrs_cfg #(
        .GRID_COLUMNS (GRID_COLUMNS),
        .GRID_ROWS    (GRID_ROWS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    cgrs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    cgrs_dp #(
        .GRID_COLUMNS (GRID_COLUMNS),
        .GRID_ROWS    (GRID_ROWS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cfg      (cfg),
        .cmd      (cmd),
        .sts      (sts),
        .out_data (out_data)
    );

`ifndef SYNTH
    // a finished item always shows up as a result
    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid)
        else $error("result not presented after finish");

    // no item is taken while a sweep is running
    a_sweep_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sweep_step |-> !in_ready)
        else $error("input ready during sweep");

    // a rejected operation never returns a cap
    a_reject_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_OK |-> out_data.read_cap == '0)
        else $error("cap returned with error status");

    // status stays within the defined codes
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.status == ST_OK || out_data.status == ST_GLOBAL ||
                      out_data.status == ST_X || out_data.status == ST_Y ||
                      out_data.status == ST_CAP)
        else $error("undefined status code");
`endif

endmodule

// ----- rtl/cgrs_cfg.sv -----
// ----------------------------------------------------------------------------
// cgrs_cfg
// Configuration registers with the grid size clamped to the built geometry.
// ----------------------------------------------------------------------------
module cgrs_cfg #(
    parameter int GRID_COLUMNS = cgrs_pkg::GRID_COLUMNS_DEF,
    parameter int GRID_ROWS    = cgrs_pkg::GRID_ROWS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [cgrs_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [cgrs_pkg::DATA_W-1:0]       cfg_wdata,
    output cgrs_pkg::cfg_t                    cfg
);
    import cgrs_pkg::*;

    logic [SIZE_W-1:0]        width_reg;
    logic [SIZE_W-1:0]        height_reg;
    logic signed [DATA_W-1:0] gmax_reg;
    logic signed [DATA_W-1:0] gmin_reg;
    logic                     auto_reg;

    // register writes; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            width_reg  <= SIZE_W'(64);
            height_reg <= SIZE_W'(64);
            gmax_reg   <= VAL_MAX;
            gmin_reg   <= '0;
            auto_reg   <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_WIDTH:  width_reg  <= cfg_wdata[SIZE_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_wdata[SIZE_W-1:0];
                CFG_GMAX:   gmax_reg   <= cfg_wdata;
                CFG_GMIN:   gmin_reg   <= cfg_wdata;
                CFG_AUTO:   auto_reg   <= cfg_wdata[0];
                default:    ;
            endcase
        end
    end

    // clamp the sizes in use to the grid that is built
    assign cfg.eff_width  = (32'(width_reg) > GRID_COLUMNS) ? SIZE_W'(GRID_COLUMNS) : width_reg;
    assign cfg.eff_height = (32'(height_reg) > GRID_ROWS) ? SIZE_W'(GRID_ROWS) : height_reg;
    assign cfg.global_max = gmax_reg;
    assign cfg.global_min = gmin_reg;
    assign cfg.auto_on    = auto_reg;

endmodule

// ----- rtl/cgrs_ctrl.sv -----
// ----------------------------------------------------------------------------
// cgrs_ctrl
// Sequencer: accepts an item, runs a grid sweep when needed, and hands the
// result to the output register.
// ----------------------------------------------------------------------------
module cgrs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  cgrs_pkg::dp_sts_t   sts,
    output cgrs_pkg::dp_cmd_t   cmd
);
    import cgrs_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    // state and output-valid registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load_item = 1'b1;
                    cmd.mem_read  = 1'b1;
                    state_next    = sts.sweep_go ? S_SWEEP : S_FINISH;
                end
            end
            S_SWEEP: begin
                cmd.sweep_step = 1'b1;
                cmd.mem_read   = 1'b1;
                if (sts.sweep_last) begin
                    state_next = S_DRAIN;
                end
            end
            // last read of the sweep is processed here
            S_DRAIN: begin
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result held until transferred
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.finish) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/cgrs_dp.sv -----
// ----------------------------------------------------------------------------
// cgrs_dp
// Datapath: value and cap memories, sweep counters, the tick and scan stage
// behind the memory read, write checks and the result register.
// ----------------------------------------------------------------------------
module cgrs_dp #(
    parameter int GRID_COLUMNS = cgrs_pkg::GRID_COLUMNS_DEF,
    parameter int GRID_ROWS    = cgrs_pkg::GRID_ROWS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cgrs_pkg::in_item_t   in_data,
    input  cgrs_pkg::cfg_t       cfg,
    input  cgrs_pkg::dp_cmd_t    cmd,
    output cgrs_pkg::dp_sts_t    sts,
    output cgrs_pkg::out_item_t  out_data
);
    import cgrs_pkg::*;

    localparam int DEPTH  = GRID_COLUMNS * GRID_ROWS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // storage
    logic signed [DATA_W-1:0] val_mem [DEPTH];
    logic signed [DATA_W-1:0] cap_mem [DEPTH];

    in_item_t                 item_reg;
    out_item_t                out_reg;
    logic [SIZE_W-1:0]        col_reg, col_next;
    logic [SIZE_W-1:0]        row_reg, row_next;
    logic                     pipe_valid_reg;
    logic [ADDR_W-1:0]        pipe_addr_reg;
    logic signed [DATA_W-1:0] val_rd_reg, cap_rd_reg;
    logic signed [DATA_W-1:0] acc_min_reg, acc_max_reg;
    logic signed [DATA_W-1:0] min_seen_reg, max_seen_reg;

    logic [ADDR_W-1:0]        in_addr, item_addr, sweep_addr, rd_addr;
    logic                     non_empty, col_last, row_last;
    logic                     sweep_go_c;
    logic                     tick_wr;
    logic signed [DATA_W-1:0] tick_sum, tick_val;
    logic                     above_gmax, x_bad, y_bad, above_cap;
    status_t                  status_c;
    logic signed [DATA_W-1:0] cap_out_c, min_next, max_next;
    logic                     wr_val_ok, wr_cap_ok;
    logic                     val_we, cap_we;
    logic [ADDR_W-1:0]        val_waddr, cap_waddr;
    logic signed [DATA_W-1:0] val_wdata, cap_wdata;

    // cell addresses, row-major
    assign in_addr    = ADDR_W'(in_data.y_index) * ADDR_W'(GRID_COLUMNS)
                      + ADDR_W'(in_data.x_index);
    assign item_addr  = ADDR_W'(item_reg.y_index) * ADDR_W'(GRID_COLUMNS)
                      + ADDR_W'(item_reg.x_index);
    assign sweep_addr = ADDR_W'(row_reg) * ADDR_W'(GRID_COLUMNS) + ADDR_W'(col_reg);
    assign rd_addr    = cmd.sweep_step ? sweep_addr : in_addr;

    // does the offered item need a sweep over the grid
    assign non_empty = (cfg.eff_width != '0) && (cfg.eff_height != '0);
    always_comb begin
        case (in_data.operation)
            OP_TICK:      sweep_go_c = cfg.auto_on && non_empty;
            OP_SCAN:      sweep_go_c = non_empty;
            OP_INIT_FILL: sweep_go_c = non_empty && !(in_data.write_value > cfg.global_max);
            default:      sweep_go_c = 1'b0;
        endcase
    end

    assign sts.sweep_go   = sweep_go_c;
    assign col_last       = (col_reg == cfg.eff_width - SIZE_W'(1));
    assign row_last       = (row_reg == cfg.eff_height - SIZE_W'(1));
    assign sts.sweep_last = col_last && row_last;

    // sweep counters: column fastest
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (cmd.load_item) begin
            col_next = '0;
            row_next = '0;
        end else if (cmd.sweep_step) begin
            if (col_last) begin
                col_next = '0;
                row_next = row_reg + SIZE_W'(1);
            end else begin
                col_next = col_reg + SIZE_W'(1);
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            col_reg        <= '0;
            row_reg        <= '0;
            pipe_valid_reg <= 1'b0;
            min_seen_reg   <= '0;
            max_seen_reg   <= '0;
        end else begin
            col_reg        <= col_next;
            row_reg        <= row_next;
            pipe_valid_reg <= cmd.sweep_step &&
                              (item_reg.operation == OP_TICK || item_reg.operation == OP_SCAN);
            if (cmd.finish) begin
                min_seen_reg <= min_next;
                max_seen_reg <= max_next;
            end
        end
    end

    // item latch, pipeline address, scan accumulators
    always_ff @(posedge clk) begin
        if (cmd.load_item) begin
            item_reg <= in_data;
        end
        pipe_addr_reg <= sweep_addr;
        if (cmd.load_item) begin
            acc_min_reg <= VAL_MAX;
            acc_max_reg <= VAL_MIN;
        end else if (pipe_valid_reg && item_reg.operation == OP_SCAN) begin
            if (val_rd_reg < acc_min_reg) begin
                acc_min_reg <= val_rd_reg;
            end
            if (val_rd_reg > acc_max_reg) begin
                acc_max_reg <= val_rd_reg;
            end
        end
    end

    // tick stage: add 1.0 below the cap, saturating
    assign tick_sum = val_rd_reg + Q_ONE;
    assign tick_val = (!val_rd_reg[DATA_W-1] && tick_sum[DATA_W-1]) ? VAL_MAX : tick_sum;
    assign tick_wr  = pipe_valid_reg && item_reg.operation == OP_TICK &&
                      (val_rd_reg < cap_rd_reg);

    // checks for single-cell operations and min/max update
    assign above_gmax = item_reg.write_value > cfg.global_max;
    assign x_bad      = {1'b0, item_reg.x_index} >= cfg.eff_width;
    assign y_bad      = {1'b0, item_reg.y_index} >= cfg.eff_height;
    assign above_cap  = item_reg.write_value > cap_rd_reg;

    always_comb begin
        status_c  = ST_OK;
        cap_out_c = '0;
        min_next  = min_seen_reg;
        max_next  = max_seen_reg;
        wr_val_ok = 1'b0;
        wr_cap_ok = 1'b0;
        case (item_reg.operation)
            OP_WRITE_VALUE: begin
                if (above_gmax)     status_c = ST_GLOBAL;
                else if (x_bad)     status_c = ST_X;
                else if (y_bad)     status_c = ST_Y;
                else if (above_cap) status_c = ST_CAP;
                else                wr_val_ok = 1'b1;
            end
            OP_WRITE_CAP: begin
                if (above_gmax)     status_c = ST_GLOBAL;
                else if (x_bad)     status_c = ST_X;
                else if (y_bad)     status_c = ST_Y;
                else                wr_cap_ok = 1'b1;
            end
            OP_READ_CAP: begin
                if (x_bad)          status_c = ST_X;
                else if (y_bad)     status_c = ST_Y;
                else                cap_out_c = cap_rd_reg;
            end
            OP_SCAN: begin
                min_next = acc_min_reg;
                max_next = acc_max_reg;
            end
            OP_INIT_FILL: begin
                if (above_gmax) begin
                    status_c = ST_GLOBAL;
                end else begin
                    min_next = cfg.global_min;
                    max_next = cfg.global_max;
                end
            end
            default: ;
        endcase
    end

    // value memory write select
    always_comb begin
        val_we    = 1'b0;
        val_waddr = item_addr;
        val_wdata = item_reg.write_value;
        if (cmd.finish && wr_val_ok) begin
            val_we = 1'b1;
        end else if (tick_wr) begin
            val_we    = 1'b1;
            val_waddr = pipe_addr_reg;
            val_wdata = tick_val;
        end else if (cmd.sweep_step && item_reg.operation == OP_INIT_FILL) begin
            val_we    = 1'b1;
            val_waddr = sweep_addr;
        end
    end

    // cap memory write select
    always_comb begin
        cap_we    = 1'b0;
        cap_waddr = item_addr;
        cap_wdata = item_reg.write_value;
        if (cmd.finish && wr_cap_ok) begin
            cap_we = 1'b1;
        end else if (cmd.sweep_step && item_reg.operation == OP_INIT_FILL) begin
            cap_we    = 1'b1;
            cap_waddr = sweep_addr;
            cap_wdata = cfg.global_max;
        end
    end

    // memories: one write and one registered read each
    always_ff @(posedge clk) begin
        if (val_we) begin
            val_mem[val_waddr] <= val_wdata;
        end
        if (cmd.mem_read) begin
            val_rd_reg <= val_mem[rd_addr];
        end
    end

    always_ff @(posedge clk) begin
        if (cap_we) begin
            cap_mem[cap_waddr] <= cap_wdata;
        end
        if (cmd.mem_read) begin
            cap_rd_reg <= cap_mem[rd_addr];
        end
    end

    // result register
    always_ff @(posedge clk) begin
        if (cmd.finish) begin
            out_reg.status      <= status_c;
            out_reg.read_cap    <= cap_out_c;
            out_reg.tracked_min <= min_next;
            out_reg.tracked_max <= max_next;
        end
    end

    assign out_data = out_reg;

endmodule
